[sv/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants and types for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int unsigned COLUMNS      = 80;
	localparam int unsigned ROWS         = 25;
	localparam int unsigned CELLS        = COLUMNS * ROWS;
	localparam int unsigned PROMPT_CELLS = 2;

	localparam int unsigned ADDR_W = $clog2(CELLS);
	localparam int unsigned CUR_W  = $clog2(CELLS + 1);
	localparam int unsigned COL_W  = $clog2(COLUMNS);

	localparam int unsigned CMD_W      = 3;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned IDX_W      = 11;
	localparam int unsigned OUT_CUR_W  = 11;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] PROMPT_CHAR0 = 8'h24;
	localparam logic [CHAR_W-1:0] PROMPT_CHAR1 = 8'h3a;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 3'd0,
		CMD_BKSP  = 3'd1,
		CMD_ENTER = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_REDO,
		ST_SCROLL_COPY,
		ST_SCROLL_BLANK,
		ST_CLEAR_FILL,
		ST_PROMPT0,
		ST_PROMPT1,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

endpackage

[sv/text_console_cursor_engine.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text-mode console: character store with cursor, scroll, clear and read.
// ----------------------------------------------------------------------------
// One word in gives one word out. A scroll (put char past the last cell, or
// enter with the cursor past the last cell) walks the character store, which
// has one read port and one write port; clear walks it too. After reset the
// store is filled with spaces in a pass during which s_axis_tready stays
// low. The next word is taken while a finished result still waits on the
// output register.
module text_console_cursor_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [2:0] command, [10:3] char_code, [21:11] cell_index
	input  logic [tcce_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [10:0] cursor_cell, [18:11] read_char
	output logic [tcce_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import tcce_pkg::*;

	logic [CHAR_W-1:0] mem [CELLS];

	state_t state_q, state_d;

	logic [CUR_W-1:0]  cursor_q, cursor_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [CUR_W-1:0]  line_q, line_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] chr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CHAR_W-1:0] rd_q, rd_d;
	logic              copy_v_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic [CHAR_W-1:0] rdata_q;
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;

	logic [CMD_W-1:0]  in_cmd;
	logic [CHAR_W-1:0] in_chr;
	logic [IDX_W-1:0]  in_idx;
	logic              in_acc;
	logic              dispatch;
	logic [CMD_W-1:0]  cmd_c;
	logic [CHAR_W-1:0] chr_c;
	logic [IDX_W-1:0]  idx_c;

	logic              cur_end;
	logic [CUR_W-1:0]  row_start;
	logic [CUR_W:0]    enter_next;
	logic              enter_wrap;
	logic              idx_ok;
	logic              bs_ok;
	logic [CUR_W-1:0]  line_inc;
	logic              out_free;
	logic              fill_last;
	logic              copy_last;

	assign in_cmd = s_axis_tdata[CMD_W-1:0];
	assign in_chr = s_axis_tdata[CMD_W +: CHAR_W];
	assign in_idx = s_axis_tdata[CMD_W+CHAR_W +: IDX_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign dispatch      = in_acc || (state_q == ST_REDO);

	assign cmd_c = (state_q == ST_IDLE) ? in_cmd : cmd_q;
	assign chr_c = (state_q == ST_IDLE) ? in_chr : chr_q;
	assign idx_c = (state_q == ST_IDLE) ? in_idx : idx_q;

	assign cur_end    = (32'(cursor_q) >= CELLS);
	assign row_start  = cursor_q - CUR_W'(col_q);
	assign enter_next = {1'b0, row_start} + (CUR_W+1)'(COLUMNS);
	assign enter_wrap = (32'(enter_next) > CELLS);
	assign idx_ok     = (32'(idx_c) < CELLS);
	assign bs_ok      = (32'(line_q) > PROMPT_CELLS) && (cursor_q != '0);
	assign line_inc   = (32'(line_q) < CELLS) ? line_q + 1'b1 : line_q;
	assign out_free   = !m_valid_q || m_axis_tready;
	assign fill_last  = (32'(cnt_q) == CELLS - 1);
	assign copy_last  = (32'(cnt_q) == CELLS - COLUMNS - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (fill_last) state_d = ST_IDLE;
			end
			ST_IDLE, ST_REDO: begin
				if (dispatch) begin
					case (cmd_c)
						CMD_PUT:   state_d = cur_end ? ST_SCROLL_COPY : ST_DONE;
						CMD_BKSP:  state_d = ST_DONE;
						CMD_ENTER: state_d = enter_wrap ? ST_SCROLL_COPY : ST_DONE;
						CMD_CLEAR: state_d = ST_CLEAR_FILL;
						CMD_READ:  state_d = idx_ok ? ST_READ_WAIT : ST_DONE;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SCROLL_COPY: begin
				if (copy_last) state_d = ST_SCROLL_BLANK;
			end
			ST_SCROLL_BLANK: begin
				if (!copy_v_s1 && fill_last) state_d = ST_REDO;
			end
			ST_CLEAR_FILL: begin
				if (fill_last) state_d = ST_PROMPT0;
			end
			ST_PROMPT0:   state_d = ST_PROMPT1;
			ST_PROMPT1:   state_d = ST_DONE;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and store access
	always_comb begin
		cursor_d  = cursor_q;
		col_d     = col_q;
		line_d    = line_q;
		cnt_d     = cnt_q;
		rd_d      = rd_q;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = SPACE_CHAR;
		mem_raddr = (state_q == ST_SCROLL_COPY) ? cnt_q + ADDR_W'(COLUMNS) : ADDR_W'(idx_c);
		case (state_q)
			ST_INIT, ST_CLEAR_FILL: begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
			end
			ST_IDLE, ST_REDO: begin
				if (dispatch) begin
					rd_d  = '0;
					cnt_d = '0;
					case (cmd_c)
						CMD_PUT: begin
							if (!cur_end) begin
								mem_we    = 1'b1;
								mem_waddr = ADDR_W'(cursor_q);
								mem_wdata = chr_c;
								cursor_d  = cursor_q + 1'b1;
								col_d     = (32'(col_q) == COLUMNS - 1) ? '0 : col_q + 1'b1;
								line_d    = line_inc;
							end
						end
						CMD_BKSP: begin
							if (bs_ok) begin
								mem_we    = 1'b1;
								mem_waddr = ADDR_W'(cursor_q - 1'b1);
								cursor_d  = cursor_q - 1'b1;
								col_d     = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - 1'b1;
								line_d    = line_q - 1'b1;
							end
						end
						CMD_ENTER: begin
							if (!enter_wrap) begin
								cursor_d = enter_next[CUR_W-1:0];
								col_d    = '0;
								line_d   = '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCROLL_COPY: begin
				cnt_d = cnt_q + 1'b1;
			end
			ST_SCROLL_BLANK: begin
				if (!copy_v_s1) begin
					mem_we = 1'b1;
					cnt_d  = cnt_q + 1'b1;
					if (fill_last) begin
						if (32'(cursor_q) >= COLUMNS) begin
							cursor_d = cursor_q - CUR_W'(COLUMNS);
						end else begin
							cursor_d = '0;
							col_d    = '0;
						end
					end
				end
			end
			ST_PROMPT0: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = PROMPT_CHAR0;
			end
			ST_PROMPT1: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(1);
				mem_wdata = PROMPT_CHAR1;
				cursor_d  = CUR_W'(PROMPT_CELLS);
				col_d     = COL_W'(PROMPT_CELLS);
				line_d    = CUR_W'(PROMPT_CELLS);
			end
			ST_READ_WAIT: begin
				rd_d = rdata_q;
			end
			default: ;
		endcase
		// row copy writes back in the cycle after its read
		if (copy_v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = dst_s1;
			mem_wdata = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cursor_q  <= '0;
			col_q     <= '0;
			line_q    <= '0;
			cnt_q     <= '0;
			copy_v_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cursor_q  <= cursor_d;
			col_q     <= col_d;
			line_q    <= line_d;
			cnt_q     <= cnt_d;
			copy_v_s1 <= (state_q == ST_SCROLL_COPY);
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= in_cmd;
			chr_q <= in_chr;
			idx_q <= in_idx;
		end
		rd_q   <= rd_d;
		dst_s1 <= cnt_q;
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= OUT_DATA_W'({rd_q, OUT_CUR_W'(cursor_q)});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_q) <= CELLS) else $error("cursor beyond store");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(line_q) <= CELLS) else $error("line length beyond saturation");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < COLUMNS) else $error("column out of range");

	a_copy_dst: assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_s1 |-> (32'(dst_s1) < CELLS - COLUMNS)) else $error("scroll copy past last row");

	a_put_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_cmd == CMD_PUT && !cur_end) |=> (cursor_q == $past(cursor_q) + 1'b1))
		else $error("put char did not advance cursor");
`endif

endmodule

[tb/tb_text_console_cursor_engine.sv]
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine
// Self-checking bench for the text console cursor engine.
// ----------------------------------------------------------------------------
// Keeps a shadow copy of the character store, cursor and line counter, and
// works out the cursor cell and read character that each command word should
// produce. A short directed run covers the field extremes, every command,
// typing past the last cell and enter on the last row. A weighted random mix
// follows. Both stream sides idle at random, with some stretches run back to
// back.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine;

	timeunit 1ns;
	timeprecision 1ps;

	import tcce_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
	localparam int unsigned STALL_LIMIT = 10000;
	localparam int unsigned RANDOM_WORDS = 600;
	localparam int unsigned MAX_MISMATCH_REPORTS = 10;

	typedef struct {
		logic [OUT_CUR_W-1:0] cursor_cell;
		logic [CHAR_W-1:0]    read_char;
	} console_result_t;

	class console_shadow;
		logic [CHAR_W-1:0] cells [CELLS];
		int unsigned cursor;
		int unsigned line_len;
		console_result_t expected_words[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned scrolls;
		int unsigned zero_holds;
		int unsigned seen [8];

		function new();
			foreach (cells[i])
				cells[i] = SPACE_CHAR;
			cursor = 0;
			line_len = 0;
			mismatches = 0;
			checked = 0;
			scrolls = 0;
			zero_holds = 0;
			foreach (seen[i])
				seen[i] = 0;
		endfunction

		function void scroll_up();
			for (int i = 0; i < CELLS - COLUMNS; i++)
				cells[i] = cells[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				cells[i] = SPACE_CHAR;
			cursor = (cursor >= COLUMNS) ? cursor - COLUMNS : 0;
			scrolls++;
		endfunction

		function void type_char(logic [CHAR_W-1:0] c);
			if (cursor >= CELLS)
				scroll_up();
			if (cursor < CELLS) begin
				cells[cursor] = c;
				cursor++;
			end
			if (line_len < CELLS)
				line_len++;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
			logic [IDX_W-1:0] idx);
			console_result_t res;
			int unsigned next_row;
			res.read_char = '0;
			seen[cmd]++;
			case (cmd)
				CMD_PUT: type_char(ch);
				CMD_BKSP: begin
					if (line_len > PROMPT_CELLS && cursor > 0) begin
						cursor--;
						line_len--;
						if (cursor < CELLS)
							cells[cursor] = SPACE_CHAR;
					end else if (line_len > PROMPT_CELLS)
						zero_holds++;
				end
				CMD_ENTER: begin
					next_row = cursor - (cursor % COLUMNS) + COLUMNS;
					if (next_row > CELLS) begin
						scroll_up();
						next_row = cursor - (cursor % COLUMNS) + COLUMNS;
						if (next_row > CELLS)
							next_row = CELLS;
					end
					cursor = next_row;
					line_len = 0;
				end
				CMD_CLEAR: begin
					foreach (cells[i])
						cells[i] = SPACE_CHAR;
					cursor = 0;
					line_len = 0;
					type_char(PROMPT_CHAR0);
					type_char(PROMPT_CHAR1);
				end
				CMD_READ: begin
					if (idx < CELLS)
						res.read_char = cells[idx];
				end
				default: ;
			endcase
			res.cursor_cell = cursor[OUT_CUR_W-1:0];
			expected_words.push_back(res);
		endfunction

		function void report(string what, int unsigned want, int unsigned got);
			mismatches++;
			if (mismatches <= MAX_MISMATCH_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_word(logic [OUT_DATA_W-1:0] w);
			console_result_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_MISMATCH_REPORTS)
					$display("%0t: unexpected result word %h", $time, w);
				return;
			end
			want = expected_words.pop_front();
			checked++;
			if (w[OUT_CUR_W-1:0] !== want.cursor_cell)
				report("cursor_cell", 32'(want.cursor_cell), 32'(w[OUT_CUR_W-1:0]));
			if (w[OUT_CUR_W +: CHAR_W] !== want.read_char)
				report("read_char", 32'(want.read_char), 32'(w[OUT_CUR_W +: CHAR_W]));
		endfunction

		function int unsigned outstanding();
			return expected_words.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	console_shadow shadow = new();
	bit gaps_on;
	int unsigned stalled_cycles = 0;

	text_console_cursor_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int unsigned pick_gap();
		return gaps_on ? $urandom_range(0, 6) : 0;
	endfunction

	task automatic issue_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
		logic [IDX_W-1:0] idx);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		for (int i = 0; i < gap; i++) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - IDX_W - CHAR_W - CMD_W){1'b0}}, idx, ch, cmd};
		do
			@(posedge clk);
		while (!s_axis_tready);
		shadow.note_command(cmd, ch, idx);
	endtask

	task automatic issue_random(logic [CMD_W-1:0] cmd);
		logic [IDX_W-1:0] idx;
		if ($urandom_range(0, 1) == 0 || cmd != CMD_READ)
			idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		else if (shadow.cursor > 8)
			idx = IDX_W'(shadow.cursor - $urandom_range(1, 8));
		else
			idx = IDX_W'($urandom_range(0, 8));
		issue_command(cmd, CHAR_W'($urandom_range(0, 255)), idx);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	// result side
	initial begin
		int unsigned gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			@(negedge clk);
			for (int i = 0; i < gap; i++) begin
				m_axis_tready <= 1'b0;
				@(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			shadow.check_word(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		int unsigned pick;
		int unsigned burst;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		gaps_on = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		issue_command(CMD_READ, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
		issue_command(CMD_READ, 8'h00, IDX_W'(CELLS));
		issue_command(CMD_READ, 8'hff, '1);
		issue_command(CMD_BKSP, 8'h00, '0);
		issue_command(CMD_PUT, 8'h00, '0);
		issue_command(CMD_PUT, 8'hff, '1);
		issue_command(CMD_BKSP, 8'h00, '0);
		issue_command(CMD_PUT, 8'h41, '0);
		issue_command(CMD_BKSP, 8'h00, '0);
		issue_command(CMD_READ, 8'h00, 11'd2);
		issue_command(CMD_ENTER, 8'h00, '0);
		issue_command(CMD_PUT, 8'h78, '0);
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
			issue_command(CMD_W'(c), 8'hff, '1);
		issue_command(CMD_CLEAR, 8'h00, '0);
		issue_command(CMD_READ, 8'h00, 11'd0);
		issue_command(CMD_READ, 8'h00, 11'd1);
		issue_command(CMD_BKSP, 8'h00, '0);
		issue_command(CMD_ENTER, 8'h00, '0);
		drain_results();

		// down to the bottom row, then enter and type past the last cell
		while (shadow.cursor != CELLS)
			issue_command(CMD_ENTER, 8'h00, '0);
		issue_command(CMD_ENTER, 8'h00, '0);
		issue_command(CMD_READ, 8'h00, IDX_W'(CELLS - COLUMNS));
		issue_command(CMD_PUT, 8'h5a, '0);
		issue_command(CMD_READ, 8'h00, IDX_W'(CELLS - COLUMNS));
		issue_command(CMD_BKSP, 8'h00, '0);
		drain_results();

		// random mix
		n = 0;
		while (n < RANDOM_WORDS) begin
			if (n % 100 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if (n == RANDOM_WORDS / 2)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 40)
				issue_random(CMD_PUT);
			else if (pick < 53)
				issue_random(CMD_BKSP);
			else if (pick < 63)
				issue_random(CMD_ENTER);
			else if (pick < 66)
				issue_random(CMD_CLEAR);
			else if (pick < 91)
				issue_random(CMD_READ);
			else if (pick < 94) begin
				burst = $urandom_range(3, 25);
				repeat (burst)
					issue_random(CMD_ENTER);
				n += burst - 1;
			end else
				issue_random(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
			n++;
		end
		gaps_on = 1'b1;
		drain_results();
		repeat (20) @(posedge clk);

		$display("Checked %0d results: put %0d, backspace %0d, enter %0d, clear %0d, read %0d",
			shadow.checked, shadow.seen[CMD_PUT], shadow.seen[CMD_BKSP],
			shadow.seen[CMD_ENTER], shadow.seen[CMD_CLEAR], shadow.seen[CMD_READ]);
		$display("Spare codes %0d, scrolls %0d, backspaces held at cell zero %0d, mismatches %0d",
			shadow.seen[5] + shadow.seen[6] + shadow.seen[7], shadow.scrolls,
			shadow.zero_holds, shadow.mismatches);
		if (shadow.mismatches == 0 && shadow.outstanding() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
